FILE: rtl/core/hct_pkg.sv
// Shared types and constants for the hysteresis cooling thermostat.
package hct_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned HystWidth = 7;
    localparam int unsigned BoundWidth = 11;
    localparam int unsigned TempWidth = 12;
    localparam int unsigned SetpointWidth = 7;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth = 16;

    localparam logic [CountWidth-1:0] LOCKOUT_RESET = 16'd1000;
    localparam logic [CountWidth-1:0] PERIOD_RESET = 16'd300;
    localparam logic [HystWidth-1:0] HYST_RESET = 7'd10;
    localparam logic [CountWidth-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic signed [BoundWidth-1:0] LOWER_RESET = 11'sd250;
    localparam logic signed [BoundWidth-1:0] UPPER_RESET = 11'sd260;
    localparam logic [SetpointWidth-1:0] SETPOINT_MIN = 7'd18;
    localparam logic [SetpointWidth-1:0] SETPOINT_MAX = 7'd35;

    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_BUTTON   = 3'd1,
        MODE_FAN_AUTO = 3'd2,
        MODE_COMP_AUTO = 3'd3,
        MODE_FAN_MAN  = 3'd4,
        MODE_SETPOINT = 3'd5
    } mode_t;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_BUTTON_LOCKOUT = 2'd0,
        CFG_CHECK_PERIOD   = 2'd1,
        CFG_HYSTERESIS     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]                   mode;
        logic signed [TempWidth-1:0]  temperature;
        logic                         switch_on;
        logic [SetpointWidth-1:0]     setpoint;
    } item_t;

    typedef struct packed {
        logic fan_on;
        logic compressor_on;
        logic auto_enabled;
        logic auto_toggled;
        logic setpoint_accepted;
    } result_t;

    typedef struct packed {
        logic [CountWidth-1:0] button_lockout_ms;
        logic [CountWidth-1:0] check_period_ms;
        logic [HystWidth-1:0]  hysteresis_tenths;
    } cfg_t;

endpackage

FILE: rtl/core/hysteresis_cooling_thermostat.sv
// Top level of the event-driven two-relay cooling thermostat.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------
//   event    | item_valid / item_ready    | item (hct_pkg::item_t)
//   result   | result_valid / result_ready| result (hct_pkg::result_t)
//   config   | cfg_we                     | cfg_index, cfg_data
//
// One event per cycle is sustained while results are taken. An event is registered
// on transfer, and its result is registered when the event advances.
// While a result waits for its transfer, the input register takes one more event
// only if it is empty.
// Reset clears the relays, modes and counters and loads the register defaults.
// A stalled result holds the input stage, which then drops item_ready.
module hysteresis_cooling_thermostat (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  hct_pkg::item_t                        item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output hct_pkg::result_t                      result,
    input  logic                                  cfg_we,
    input  logic [hct_pkg::CfgIndexWidth-1:0]     cfg_index,
    input  logic [hct_pkg::CfgDataWidth-1:0]      cfg_data
);
    import hct_pkg::*;

    logic    stage_valid_reg, stage_valid_next;
    item_t   stage_item_reg;
    logic    result_valid_reg, result_valid_next;
    result_t result_reg;
    result_t core_result;
    cfg_t    cfg_reg;
    logic    advance;

    assign advance = stage_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item_ready)
        begin
            stage_valid_next = item_valid;
        end
        result_valid_next = result_valid_reg;
        if (advance)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_lockout_ms <= LOCKOUT_RESET;
            cfg_reg.check_period_ms <= PERIOD_RESET;
            cfg_reg.hysteresis_tenths <= HYST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BUTTON_LOCKOUT: cfg_reg.button_lockout_ms <= cfg_data;
                CFG_CHECK_PERIOD:   cfg_reg.check_period_ms <= cfg_data;
                CFG_HYSTERESIS:     cfg_reg.hysteresis_tenths <= cfg_data[HystWidth-1:0];
                default:
                begin
                end
            endcase
        end
    end

    hct_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .item  (stage_item_reg),
        .cfg   (cfg_reg),
        .res   (core_result)
    );

endmodule

FILE: rtl/core/hct_core.sv
// Thermostat state and its per-event update logic.
module hct_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  hct_pkg::item_t  item,
    input  hct_pkg::cfg_t   cfg,
    output hct_pkg::result_t res
);
    import hct_pkg::*;

    logic fan_reg, fan_next;
    logic comp_reg, comp_next;
    logic auto_reg, auto_next;
    logic fan_auto_reg, fan_auto_next;
    logic fan_manual_reg, fan_manual_next;
    logic signed [BoundWidth-1:0] lower_reg, lower_next;
    logic signed [BoundWidth-1:0] upper_reg, upper_next;
    logic [CountWidth-1:0] since_button_reg, since_button_next;
    logic [CountWidth-1:0] since_check_reg, since_check_next;

    logic [CountWidth-1:0] button_inc;
    logic [CountWidth-1:0] check_inc;
    logic signed [TempWidth-1:0] lower_ext;
    logic signed [TempWidth-1:0] upper_ext;
    logic [BoundWidth-1:0] sp_times_ten;
    logic toggled;
    logic accepted;

    assign button_inc = (since_button_reg == COUNT_MAX) ? COUNT_MAX
                                                         : since_button_reg + 16'd1;
    assign check_inc = (since_check_reg == COUNT_MAX) ? COUNT_MAX
                                                       : since_check_reg + 16'd1;
    assign lower_ext = TempWidth'(lower_reg);
    assign upper_ext = TempWidth'(upper_reg);
    // Setpoint times ten as 8x plus 2x.
    assign sp_times_ten = {1'b0, item.setpoint, 3'b000}
                        + {3'b000, item.setpoint, 1'b0};

    always_comb
    begin
        fan_next = fan_reg;
        comp_next = comp_reg;
        auto_next = auto_reg;
        fan_auto_next = fan_auto_reg;
        fan_manual_next = fan_manual_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        since_button_next = since_button_reg;
        since_check_next = since_check_reg;
        toggled = 1'b0;
        accepted = 1'b0;

        case (item.mode)
            MODE_TICK:
            begin
                since_button_next = button_inc;
                since_check_next = check_inc;
                if (check_inc > cfg.check_period_ms)
                begin
                    since_check_next = '0;
                    if (auto_reg)
                    begin
                        // The off rule wins over the on rule when the bounds cross.
                        if (upper_ext <= item.temperature)
                        begin
                            fan_next = 1'b1;
                            comp_next = 1'b1;
                        end
                        if (lower_ext >= item.temperature)
                        begin
                            if (!fan_auto_reg && !fan_manual_reg)
                            begin
                                fan_next = 1'b0;
                            end
                            comp_next = 1'b0;
                        end
                    end
                    else if (!fan_manual_reg)
                    begin
                        fan_next = 1'b0;
                    end
                end
            end
            MODE_BUTTON:
            begin
                if (since_button_reg > cfg.button_lockout_ms)
                begin
                    since_button_next = '0;
                    toggled = 1'b1;
                    auto_next = !auto_reg;
                    if (auto_reg)
                    begin
                        fan_next = 1'b0;
                        comp_next = 1'b0;
                    end
                end
            end
            MODE_FAN_AUTO:
            begin
                fan_auto_next = item.switch_on;
                if (!item.switch_on && !auto_reg)
                begin
                    comp_next = 1'b0;
                    if (!fan_manual_reg)
                    begin
                        fan_next = 1'b0;
                    end
                end
            end
            MODE_COMP_AUTO:
            begin
                auto_next = item.switch_on;
                if (!item.switch_on)
                begin
                    comp_next = 1'b0;
                    if (!fan_manual_reg)
                    begin
                        fan_next = 1'b0;
                    end
                end
            end
            MODE_FAN_MAN:
            begin
                fan_manual_next = item.switch_on;
                if (item.switch_on)
                begin
                    fan_next = 1'b1;
                end
                else if (!auto_reg)
                begin
                    fan_next = 1'b0;
                end
            end
            MODE_SETPOINT:
            begin
                if (item.setpoint inside {[SETPOINT_MIN:SETPOINT_MAX]})
                begin
                    accepted = 1'b1;
                    lower_next = sp_times_ten;
                    upper_next = sp_times_ten + {4'b0000, cfg.hysteresis_tenths};
                end
            end
            default:
            begin
            end
        endcase

        res.fan_on = fan_next;
        res.compressor_on = comp_next;
        res.auto_enabled = auto_next;
        res.auto_toggled = toggled;
        res.setpoint_accepted = accepted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_reg <= 1'b0;
            comp_reg <= 1'b0;
            auto_reg <= 1'b0;
            fan_auto_reg <= 1'b0;
            fan_manual_reg <= 1'b0;
            lower_reg <= LOWER_RESET;
            upper_reg <= UPPER_RESET;
            since_button_reg <= '0;
            since_check_reg <= '0;
        end
        else if (en)
        begin
            fan_reg <= fan_next;
            comp_reg <= comp_next;
            auto_reg <= auto_next;
            fan_auto_reg <= fan_auto_next;
            fan_manual_reg <= fan_manual_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            since_button_reg <= since_button_next;
            since_check_reg <= since_check_next;
        end
    end

endmodule

FILE: rtl/core/hct_checker.sv
// Port-level checks for the thermostat and their bind to the top level.
module hct_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  item_valid,
    input logic                                  item_ready,
    input hct_pkg::item_t                        item,
    input logic                                  result_valid,
    input logic                                  result_ready,
    input hct_pkg::result_t                      result
);
    import hct_pkg::*;

    // A waiting event must hold until its transfer.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_ready |=> item_valid && $stable(item))
    else $error("event changed while waiting");

    // A stalled result must hold until its transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    // Every new result comes from an event transferred through the input register.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
    else $error("result appeared without a matching event");

    // The compressor only runs under automatic control.
    a_comp_needs_auto: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.compressor_on |-> result.auto_enabled)
    else $error("compressor on while auto mode is off");

    // A press that turns auto mode off drops both relays.
    a_toggle_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.auto_toggled && !result.auto_enabled
        |-> !result.fan_on && !result.compressor_on)
    else $error("relays left on after auto mode was switched off");

endmodule

bind hysteresis_cooling_thermostat hct_checker u_hct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
